@@ rtl/sqct_pkg.sv @@
// Shared constants and helpers for the sprite quad corner transform.
// Holds field widths, anchor codes, the quarter-wave sine generator and the
// output saturation. No dependencies.
package sqct_pkg;

    localparam int DEF_ANGLE_BITS     = 12;
    localparam int DEF_TRIG_FRAC_BITS = 14;

    localparam int POS_W      = 16;
    localparam int EXT_W      = 12;
    localparam int SCALE_W    = 12;
    localparam int SCALE_FRAC = 8;
    localparam int MODE_W     = 2;
    localparam int COORD_W    = 16;

    // width * scale, both as signed operands
    localparam int PROD_W   = EXT_W + 1 + SCALE_W;
    // corner offset before rotation, left-top mode reaches -32760 to +32744
    localparam int CORNER_W = 17;
    // rotated offset after the fraction bits are dropped
    localparam int ROT_W    = CORNER_W + 3;
    localparam int SUM_W    = ROT_W + 1;

    localparam logic [MODE_W-1:0] ANCHOR_CENTRE   = 2'd0;
    localparam logic [MODE_W-1:0] ANCHOR_LEFT_TOP = 2'd1;

    localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                  64'd110, 64'd156, 64'd210, 64'd272};

    // Sine magnitude of r steps into a quarter turn, frac_bits fraction bits.
    // Used at elaboration only to fill the sine ROM.
    function automatic logic [16:0] quarter_sine(input int angle_bits,
                                                 input int frac_bits,
                                                 input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      res;
        x    = (r * PIHALF_Q30) >> (angle_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 8; k++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        res = (sum + (longint'(1) << (29 - frac_bits))) >>> (30 - frac_bits);
        if (res > (longint'(1) << frac_bits))
            res = longint'(1) << frac_bits;
        return res[16:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32767);
        lo = -SUM_W'(32768);
        if (v > hi)
            return COORD_W'(hi);
        else if (v < lo)
            return COORD_W'(lo);
        else
            return COORD_W'(v);
    endfunction

endpackage

@@ rtl/sprite_quad_corner_transform.sv @@
// Sprite quad corner transform: scale, anchor, rotate and translate one sprite
// into four screen corners. Five-stage pipeline with a quarter-wave sine ROM.
// Depends on sqct_pkg.
//
//   channel | handshake     | words
//   --------+---------------+------------------------------------------------
//   in      | start / busy  | pos_x pos_y width height scale_x scale_y angle
//           |               | anchor_mode
//   out     | done          | top_left_x/y top_right_x/y bottom_left_x/y
//           |               | bottom_right_x/y
//
// One word enters per cycle; busy stays low, so start is taken every cycle.
// Each result appears on done once its word has passed the stages in order:
// ROM read, corner placement, multiply, rotate sum, translate and saturate.
// The receiver cannot stall; results are shown for one cycle only.
// Reset clears the valid bits only; there is no clearing pass, the ROM is
// constant.
module sprite_quad_corner_transform
    import sqct_pkg::*;
#(
    parameter int ANGLE_BITS     = DEF_ANGLE_BITS,
    parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [POS_W-1:0]       pos_x,
    input  logic signed [POS_W-1:0]       pos_y,
    input  logic        [EXT_W-1:0]       width,
    input  logic        [EXT_W-1:0]       height,
    input  logic signed [SCALE_W-1:0]     scale_x,
    input  logic signed [SCALE_W-1:0]     scale_y,
    input  logic        [ANGLE_BITS-1:0]  angle,
    input  logic        [MODE_W-1:0]      anchor_mode,
    output logic                          done,
    output logic signed [COORD_W-1:0]     top_left_x,
    output logic signed [COORD_W-1:0]     top_left_y,
    output logic signed [COORD_W-1:0]     top_right_x,
    output logic signed [COORD_W-1:0]     top_right_y,
    output logic signed [COORD_W-1:0]     bottom_left_x,
    output logic signed [COORD_W-1:0]     bottom_left_y,
    output logic signed [COORD_W-1:0]     bottom_right_x,
    output logic signed [COORD_W-1:0]     bottom_right_y
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W   = ANGLE_BITS - 1;
    localparam int MAG_W   = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
    localparam int MUL_W   = CORNER_W + TRIG_W;
    localparam int RSUM_W  = MUL_W + 1;
    localparam int LATENCY = 5;

    localparam logic signed [PROD_W-1:0] HALF_BIAS = PROD_W'((1 << (SCALE_FRAC + 1)) - 1);
    localparam logic signed [PROD_W-1:0] FULL_BIAS = PROD_W'((1 << SCALE_FRAC) - 1);
    localparam logic signed [PROD_W-1:0] NO_BIAS   = '0;
    localparam logic signed [RSUM_W-1:0] TRIG_BIAS = RSUM_W'((1 << TRIG_FRAC_BITS) - 1);
    localparam logic signed [RSUM_W-1:0] NO_RBIAS  = '0;

    typedef logic [MAG_W-1:0] sin_rom_t [0:QUARTER];

    function automatic sin_rom_t build_rom();
        sin_rom_t    rom;
        logic [16:0] mag;
        for (int i = 0; i <= QUARTER; i++)
        begin
            mag    = quarter_sine(ANGLE_BITS, TRIG_FRAC_BITS, 64'(i));
            rom[i] = mag[MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam sin_rom_t SIN_ROM = build_rom();

    // ---------------- valid chain ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // ---------------- stage 1: ROM address, extent products ----------------
    logic [1:0]       quad;
    logic [IDX_W-1:0] r_fwd;
    logic [IDX_W-1:0] r_rev;
    logic [IDX_W-1:0] sin_idx;
    logic [IDX_W-1:0] cos_idx;

    assign quad    = angle[ANGLE_BITS-1:ANGLE_BITS-2];
    assign r_fwd   = {1'b0, angle[ANGLE_BITS-3:0]};
    assign r_rev   = IDX_W'(QUARTER) - r_fwd;
    // odd quadrants run the quarter wave backwards; cosine is a quarter ahead
    assign sin_idx = quad[0] ? r_rev : r_fwd;
    assign cos_idx = quad[0] ? r_fwd : r_rev;

    logic        [MAG_W-1:0]  sin_mag_reg, cos_mag_reg;
    logic                     sin_neg_reg, cos_neg_reg;
    logic signed [PROD_W-1:0] pw_reg, ph_reg;
    logic        [MODE_W-1:0] mode_reg;
    logic signed [POS_W-1:0]  px1_reg, py1_reg;

    always_ff @(posedge clk)
    begin
        sin_mag_reg <= SIN_ROM[sin_idx];
        cos_mag_reg <= SIN_ROM[cos_idx];
        sin_neg_reg <= quad[1];
        cos_neg_reg <= quad[1] ^ quad[0];
        pw_reg      <= $signed({1'b0, width}) * scale_x;
        ph_reg      <= $signed({1'b0, height}) * scale_y;
        mode_reg    <= anchor_mode;
        px1_reg     <= pos_x;
        py1_reg     <= pos_y;
    end

    // ---------------- stage 2: signs and corner placement ----------------
    logic signed [TRIG_W-1:0]   sin_pos, cos_pos, sin_next, cos_next;
    logic signed [PROD_W-1:0]   pw_half, ph_half, pw_full, ph_full;
    logic signed [CORNER_W-1:0] hw, hh, fw, fh;
    logic signed [CORNER_W-1:0] x_next [0:1];
    logic signed [CORNER_W-1:0] y_next [0:1];

    assign sin_pos  = $signed({1'b0, sin_mag_reg});
    assign cos_pos  = $signed({1'b0, cos_mag_reg});
    assign sin_next = sin_neg_reg ? -sin_pos : sin_pos;
    assign cos_next = cos_neg_reg ? -cos_pos : cos_pos;

    // truncate toward zero: bias negative products before the shift
    assign pw_half = (pw_reg + (pw_reg[PROD_W-1] ? HALF_BIAS : NO_BIAS)) >>> (SCALE_FRAC + 1);
    assign ph_half = (ph_reg + (ph_reg[PROD_W-1] ? HALF_BIAS : NO_BIAS)) >>> (SCALE_FRAC + 1);
    assign pw_full = (pw_reg + (pw_reg[PROD_W-1] ? FULL_BIAS : NO_BIAS)) >>> SCALE_FRAC;
    assign ph_full = (ph_reg + (ph_reg[PROD_W-1] ? FULL_BIAS : NO_BIAS)) >>> SCALE_FRAC;
    assign hw = CORNER_W'(pw_half);
    assign hh = CORNER_W'(ph_half);
    assign fw = CORNER_W'(pw_full);
    assign fh = CORNER_W'(ph_full);

    always_comb
    begin
        case (mode_reg)
            ANCHOR_CENTRE:
            begin
                x_next[0] = -hw;
                x_next[1] = hw;
                y_next[0] = -hh;
                y_next[1] = hh;
            end
            ANCHOR_LEFT_TOP:
            begin
                x_next[0] = '0;
                x_next[1] = fw;
                y_next[0] = '0;
                y_next[1] = fh;
            end
            default:
            begin
                x_next[0] = '0;
                x_next[1] = '0;
                y_next[0] = '0;
                y_next[1] = '0;
            end
        endcase
    end

    logic signed [TRIG_W-1:0]   sin_reg, cos_reg;
    logic signed [CORNER_W-1:0] x_reg [0:1];
    logic signed [CORNER_W-1:0] y_reg [0:1];
    logic signed [POS_W-1:0]    px2_reg, py2_reg;

    always_ff @(posedge clk)
    begin
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
        x_reg[0] <= x_next[0];
        x_reg[1] <= x_next[1];
        y_reg[0] <= y_next[0];
        y_reg[1] <= y_next[1];
        px2_reg  <= px1_reg;
        py2_reg  <= py1_reg;
    end

    // ---------------- stage 3: products ----------------
    logic signed [MUL_W-1:0] xc_reg [0:1];
    logic signed [MUL_W-1:0] xs_reg [0:1];
    logic signed [MUL_W-1:0] yc_reg [0:1];
    logic signed [MUL_W-1:0] ys_reg [0:1];
    logic signed [POS_W-1:0] px3_reg, py3_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            xc_reg[k] <= x_reg[k] * cos_reg;
            xs_reg[k] <= x_reg[k] * sin_reg;
            yc_reg[k] <= y_reg[k] * cos_reg;
            ys_reg[k] <= y_reg[k] * sin_reg;
        end
        px3_reg <= px2_reg;
        py3_reg <= py2_reg;
    end

    // ---------------- stage 4: rotation sums ----------------
    // corner i: bit 0 picks right over left, bit 1 picks bottom over top
    logic signed [RSUM_W-1:0] rx_sum  [0:3];
    logic signed [RSUM_W-1:0] ry_sum  [0:3];
    logic signed [ROT_W-1:0]  rot_next [0:7];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rx_sum[i] = RSUM_W'(xc_reg[i % 2]) - RSUM_W'(ys_reg[i / 2]);
            ry_sum[i] = RSUM_W'(xs_reg[i % 2]) + RSUM_W'(yc_reg[i / 2]);
            rot_next[2*i]   = ROT_W'((rx_sum[i] + (rx_sum[i][RSUM_W-1] ? TRIG_BIAS : NO_RBIAS))
                                     >>> TRIG_FRAC_BITS);
            rot_next[2*i+1] = ROT_W'((ry_sum[i] + (ry_sum[i][RSUM_W-1] ? TRIG_BIAS : NO_RBIAS))
                                     >>> TRIG_FRAC_BITS);
        end
    end

    logic signed [ROT_W-1:0] rot_reg [0:7];
    logic signed [POS_W-1:0] px4_reg, py4_reg;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 8; j++)
            rot_reg[j] <= rot_next[j];
        px4_reg <= px3_reg;
        py4_reg <= py3_reg;
    end

    // ---------------- stage 5: translate and saturate ----------------
    logic signed [COORD_W-1:0] out_next [0:7];
    logic signed [COORD_W-1:0] out_reg  [0:7];

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            if (j % 2 == 0)
                out_next[j] = sat_coord(SUM_W'(px4_reg) + SUM_W'(rot_reg[j]));
            else
                out_next[j] = sat_coord(SUM_W'(py4_reg) + SUM_W'(rot_reg[j]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 8; j++)
            out_reg[j] <= out_next[j];
    end

    assign top_left_x     = out_reg[0];
    assign top_left_y     = out_reg[1];
    assign top_right_x    = out_reg[2];
    assign top_right_y    = out_reg[3];
    assign bottom_left_x  = out_reg[4];
    assign bottom_left_y  = out_reg[5];
    assign bottom_right_x = out_reg[6];
    assign bottom_right_y = out_reg[7];

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word did not reach the output on time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching start");

    a_top_left_at_anchor: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(anchor_mode, LATENCY) != ANCHOR_CENTRE) |->
            (top_left_x == $past(pos_x, LATENCY)) && (top_left_y == $past(pos_y, LATENCY)))
        else $error("top-left corner moved off the anchor outside centre mode");

endmodule
